>>> rtl/fpec_pkg.sv
package fpec_pkg;

  // Item kinds carried by the mode field.
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_SPHERE  = 2'd2;
  localparam logic [1:0] MODE_POINT   = 2'd3;

  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned WORD_COUNT  = PLANE_COUNT * 4;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       wr_mat;
    logic       cap;
    logic       ld_w;
    logic       ld_e;
    logic       halve;
    logic       sqm;
    logic       sqa;
    logic       rt_init;
    logic       rt_step;
    logic       dv_init;
    logic       dv_step;
    logic       st;
    logic       q_issue;
    logic [2:0] p;
    logic [1:0] k;
    logic [5:0] it;
    logic [4:0] qw;
  } cmd_t;

  // Matrix row combined with the fourth row for each plane.
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    logic [1:0] r;
    case (p[2:1])
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/frustum_plane_extract_and_cull.sv
// Frustum plane extraction and sphere/point culling, signed Q16.16.
// Items enter on start_i while busy_o is low, with mode_i choosing the kind.
// A load item writes one matrix element (index = column*4 + row) in the
// accept cycle and leaves busy_o low, so loads may follow back to back.
// An extract item rebuilds the six planes: per plane, matrix reads, three
// squares, a 32-step square root and four 49-step divisions, busy the
// whole time.
// A sphere or point query walks the 24 stored plane words through one
// shared multiplier, one word a cycle; valid_o is high for exactly one
// cycle, with visible_o holding the result in that cycle. The next item
// can be accepted once busy_o falls after the result.
// Loads and extracts give no result. The receiver cannot stall: a result
// is shown once and must be taken in that cycle.
// Reset clears the planes to zero, so queries before the first extract
// answer visible; matrix contents are undefined until loaded.
module frustum_plane_extract_and_cull (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [30:0]        radius_i,
  output logic               valid_o,
  output logic               visible_o
);

  fpec_pkg::cmd_t cmd;

  // Sequencer.
  fpec_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .cmd_o   (cmd)
  );

  // Arithmetic and storage.
  fpec_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .mode_i          (mode_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .radius_i        (radius_i),
    .visible_o       (visible_o)
  );

endmodule

>>> rtl/fpec_ctrl.sv
module fpec_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  output logic               busy_o,
  output logic               valid_o,
  output fpec_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EW   = 4'd1;
  localparam logic [3:0] S_EE   = 4'd2;
  localparam logic [3:0] S_HALF = 4'd3;
  localparam logic [3:0] S_SQM  = 4'd4;
  localparam logic [3:0] S_SQA  = 4'd5;
  localparam logic [3:0] S_RTI  = 4'd6;
  localparam logic [3:0] S_RT   = 4'd7;
  localparam logic [3:0] S_DVI  = 4'd8;
  localparam logic [3:0] S_DV   = 4'd9;
  localparam logic [3:0] S_ST   = 4'd10;
  localparam logic [3:0] S_Q    = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0] state_q, state_d;
  logic [2:0] p_q, p_d;
  logic [1:0] k_q, k_d;
  logic [5:0] it_q, it_d;
  logic [4:0] cnt_q, cnt_d;
  logic       acc;

  assign acc     = start_i && (state_q == S_IDLE);
  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

  // Next state, counters and commands.
  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    k_d     = k_q;
    it_d    = it_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.p  = p_q;
    cmd_o.k  = k_q;
    cmd_o.it = it_q;
    cmd_o.qw = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          cmd_o.cap = 1'b1;
          case (mode_i)
            fpec_pkg::MODE_LOAD: cmd_o.wr_mat = 1'b1;
            fpec_pkg::MODE_EXTRACT: begin
              p_d     = '0;
              k_d     = '0;
              state_d = S_EW;
            end
            default: begin
              cnt_d   = '0;
              state_d = S_Q;
            end
          endcase
        end
      end
      S_EW: begin
        cmd_o.ld_w = 1'b1;
        state_d    = S_EE;
      end
      S_EE: begin
        cmd_o.ld_e = 1'b1;
        k_d        = k_q + 2'd1;
        state_d    = (k_q == 2'd3) ? S_HALF : S_EW;
      end
      S_HALF: begin
        cmd_o.halve = 1'b1;
        k_d         = '0;
        state_d     = S_SQM;
      end
      S_SQM: begin
        cmd_o.sqm = 1'b1;
        state_d   = S_SQA;
      end
      S_SQA: begin
        cmd_o.sqa = 1'b1;
        if (k_q == 2'd2) begin
          k_d     = '0;
          state_d = S_RTI;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_SQM;
        end
      end
      S_RTI: begin
        cmd_o.rt_init = 1'b1;
        it_d          = 6'd31;
        state_d       = S_RT;
      end
      S_RT: begin
        cmd_o.rt_step = 1'b1;
        it_d          = it_q - 6'd1;
        if (it_q == '0) begin
          k_d     = '0;
          state_d = S_DVI;
        end
      end
      S_DVI: begin
        cmd_o.dv_init = 1'b1;
        it_d          = 6'd48;
        state_d       = S_DV;
      end
      S_DV: begin
        cmd_o.dv_step = 1'b1;
        it_d          = it_q - 6'd1;
        if (it_q == '0) begin
          state_d = S_ST;
        end
      end
      S_ST: begin
        cmd_o.st = 1'b1;
        k_d      = k_q + 2'd1;
        if (k_q == 2'd3) begin
          if (p_q == 3'(fpec_pkg::PLANE_COUNT - 1)) begin
            state_d = S_IDLE;
          end else begin
            p_d     = p_q + 3'd1;
            state_d = S_EW;
          end
        end else begin
          state_d = S_DVI;
        end
      end
      S_Q: begin
        cmd_o.q_issue = (cnt_q < 5'(fpec_pkg::WORD_COUNT));
        cnt_d         = cnt_q + 5'd1;
        if (cnt_q == 5'(fpec_pkg::WORD_COUNT)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      k_q     <= '0;
      it_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      k_q     <= k_d;
      it_q    <= it_d;
      cnt_q   <= cnt_d;
    end
  end

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> (state_q == S_IDLE))
    else $error("result strobe lasted more than one cycle");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (mode_i == fpec_pkg::MODE_SPHERE || mode_i == fpec_pkg::MODE_POINT))
    |=> (state_q == S_Q))
    else $error("query item did not start the plane walk");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q) |-> (cnt_q <= 5'(fpec_pkg::WORD_COUNT)))
    else $error("plane word counter overran");

endmodule

>>> rtl/fpec_dp.sv
module fpec_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpec_pkg::cmd_t     cmd_i,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [30:0]        radius_i,
  output logic               visible_o
);

  logic signed [31:0] mat_q [16];
  logic signed [31:0] plane_q [fpec_pkg::WORD_COUNT];
  logic signed [31:0] w_q;
  logic signed [32:0] v_q [4];
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [65:0] lim_q, acc_q, prod_q;
  logic [63:0]        s_q, rx_q, res_q;
  logic [31:0]        rem_q;
  logic [48:0]        num_q;
  logic               pv_q, plast_q, vis_q;

  logic [3:0]         rd_addr;
  logic signed [31:0] rd_data;
  logic               neg;
  logic signed [32:0] e_ext, w_ext;
  logic               big;
  logic signed [32:0] vk;
  logic [32:0]        mag;
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] word, opnd;
  logic [63:0]        bitv, t_sum;
  logic [31:0]        len;
  logic [32:0]        r2;
  logic               qbit;
  logic signed [31:0] qword;
  logic signed [65:0] sum;

  // Matrix read port and raw plane component.
  assign rd_addr = {cmd_i.k, cmd_i.ld_w ? 2'd3 : fpec_pkg::plane_row(cmd_i.p)};
  assign rd_data = mat_q[rd_addr];
  assign neg     = cmd_i.p[0];
  assign e_ext   = 33'(rd_data);
  assign w_ext   = 33'(w_q);

  // Normal components of magnitude 2^31 or more force halving.
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((v_q[i][32] != v_q[i][31]) || (v_q[i] == {2'b11, 31'd0})) begin
        big = 1'b1;
      end
    end
  end

  assign vk  = v_q[cmd_i.k];
  assign mag = vk[32] ? 33'(-vk) : 33'(vk);

  // Shared multiplier: squares during extraction, dot products for queries.
  assign word = plane_q[cmd_i.qw];
  always_comb begin
    case (cmd_i.qw[1:0])
      2'd0:    opnd = x_q;
      2'd1:    opnd = y_q;
      2'd2:    opnd = z_q;
      default: opnd = 32'sh0001_0000;
    endcase
    if (cmd_i.q_issue) begin
      mul_a = 33'(word);
      mul_b = 33'(opnd);
    end else begin
      mul_a = {1'b0, mag[31:0]};
      mul_b = {1'b0, mag[31:0]};
    end
  end

  // Square root step and restoring division step.
  assign bitv  = 64'd1 << {cmd_i.it[4:0], 1'b0};
  assign t_sum = res_q + bitv;
  assign len   = res_q[31:0];
  assign r2    = {rem_q, num_q[48]};
  assign qbit  = (r2 >= {1'b0, len});

  // Quotient with sign, saturation and the zero-length case.
  always_comb begin
    if (len == '0) begin
      qword = '0;
    end else if (!vk[32]) begin
      qword = (num_q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : num_q[31:0];
    end else begin
      qword = (num_q > 49'h0_8000_0000) ? 32'sh8000_0000 : -num_q[31:0];
    end
  end

  assign sum = acc_q + prod_q;

  // Matrix store, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mat) begin
      mat_q[element_index_i] <= element_value_i;
    end
  end

  // Plane store, all zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fpec_pkg::WORD_COUNT; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cmd_i.st) begin
      plane_q[{cmd_i.p, cmd_i.k}] <= qword;
    end
  end

  // Extraction arithmetic registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_w) begin
      w_q <= rd_data;
    end
    if (cmd_i.ld_e) begin
      v_q[cmd_i.k] <= neg ? (w_ext - e_ext) : (w_ext + e_ext);
    end
    if (cmd_i.halve) begin
      s_q <= '0;
      if (big) begin
        for (int i = 0; i < 4; i++) begin
          v_q[i] <= v_q[i] >>> 1;
        end
      end
    end
    prod_q <= mul_a * mul_b;
    if (cmd_i.sqa) begin
      s_q <= s_q + prod_q[63:0];
    end
    if (cmd_i.rt_init) begin
      rx_q  <= s_q;
      res_q <= '0;
    end
    if (cmd_i.rt_step) begin
      if (rx_q >= t_sum) begin
        rx_q  <= rx_q - t_sum;
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (cmd_i.dv_init) begin
      num_q <= {mag, 16'd0};
      rem_q <= '0;
    end
    if (cmd_i.dv_step) begin
      rem_q <= qbit ? 32'(r2 - {1'b0, len}) : r2[31:0];
      num_q <= {num_q[47:0], qbit};
    end
    if (cmd_i.cap) begin
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      z_q   <= pos_z_i;
      lim_q <= (mode_i == fpec_pkg::MODE_SPHERE) ? -66'({radius_i, 16'd0}) : '0;
    end
  end

  // Query accumulation and cull decision.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      plast_q <= 1'b0;
      acc_q   <= '0;
      vis_q   <= 1'b1;
    end else begin
      pv_q    <= cmd_i.q_issue;
      plast_q <= (cmd_i.qw[1:0] == 2'd3);
      if (cmd_i.cap) begin
        acc_q <= '0;
        vis_q <= 1'b1;
      end else if (pv_q) begin
        if (plast_q) begin
          acc_q <= '0;
          if (sum < lim_q) begin
            vis_q <= 1'b0;
          end
        end else begin
          acc_q <= sum;
        end
      end
    end
  end

  assign visible_o = vis_q;

  a_cap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cap |-> !pv_q)
    else $error("query captured while products were in flight");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.q_issue, cmd_i.sqm, cmd_i.rt_step, cmd_i.dv_step}))
    else $error("conflicting datapath commands");

  a_store_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.st |-> (cmd_i.p < 3'(fpec_pkg::PLANE_COUNT)))
    else $error("plane store index out of range");

endmodule
